/* sv/cbm_pkg.sv */
// Package: request and result types and the write decode constants of the bank mapper.
`timescale 1ns / 1ps
`default_nettype none
package cbm_pkg;

    localparam logic [15:0] ADDR_MASK = 16'hF800;
    localparam logic [15:0] ADDR_CHR0 = 16'h8800;
    localparam logic [15:0] ADDR_CHR1 = 16'h9800;
    localparam logic [15:0] ADDR_CHR2 = 16'hA800;
    localparam logic [15:0] ADDR_CHR3 = 16'hB800;
    localparam logic [15:0] ADDR_CNT  = 16'hC800;
    localparam logic [15:0] ADDR_ARM  = 16'hD800;
    localparam logic [15:0] ADDR_CMD  = 16'hE800;

    localparam logic [8:0] LAST_IRQ_LINE = 9'd240;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Bit positions inside the command byte and the arm write
    localparam int CMD_HIGH_BYTE_BIT = 0;
    localparam int CMD_MIRROR_BIT    = 5;
    localparam int ARM_DATA_BIT      = 4;

    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  data;
        logic [8:0]  scanline;
        logic        rendering_on;
    } cbm_req_t;

    typedef struct packed {
        logic [7:0] chr_bank_0;
        logic [7:0] chr_bank_1;
        logic [7:0] chr_bank_2;
        logic [7:0] chr_bank_3;
        logic [2:0] prg_bank;
        logic       mirror_horizontal;
        logic       irq_pulse;
    } cbm_res_t;

endpackage
`default_nettype wire

/* sv/cbm_core.sv */
// Mapper state: bank, command, line counter and arm registers with their update logic.
`timescale 1ns / 1ps
`default_nettype none
module cbm_core
    import cbm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire cbm_req_t req,
    output cbm_res_t      res
);

    logic [7:0]  chr_reg [4];
    logic [7:0]  chr_next [4];
    logic [7:0]  cmd_reg;
    logic [7:0]  cmd_next;
    logic [15:0] cnt_reg;
    logic [15:0] cnt_next;
    logic        armed_reg;
    logic        armed_next;
    logic        pulse;
    logic [15:0] cnt_dec;
    logic        tick_live;

    assign cnt_dec   = cnt_reg - 16'd1;
    assign tick_live = (req.scanline <= LAST_IRQ_LINE) && req.rendering_on
                       && armed_reg && (cnt_reg != 16'd0);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            chr_next[i] = chr_reg[i];
        end
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        armed_next = armed_reg;
        pulse      = 1'b0;
        if (req.action == ACT_WRITE)
        begin
            case (req.address & ADDR_MASK)
                ADDR_CHR0: chr_next[0] = req.data;
                ADDR_CHR1: chr_next[1] = req.data;
                ADDR_CHR2: chr_next[2] = req.data;
                ADDR_CHR3: chr_next[3] = req.data;
                ADDR_CNT:
                begin
                    if (cmd_reg[CMD_HIGH_BYTE_BIT])
                    begin
                        cnt_next = {req.data, cnt_reg[7:0]};
                    end
                    else
                    begin
                        cnt_next = {cnt_reg[15:8], req.data};
                    end
                end
                ADDR_ARM:  armed_next = req.data[ARM_DATA_BIT];
                ADDR_CMD:  cmd_next   = req.data;
                default:   ;
            endcase
        end
        else if (tick_live)
        begin
            cnt_next = cnt_dec;
            if (cnt_dec == 16'd0)
            begin
                armed_next = 1'b0;
                pulse      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                chr_reg[i] <= 8'd0;
            end
            cmd_reg   <= 8'd0;
            cnt_reg   <= 16'd0;
            armed_reg <= 1'b0;
        end
        else if (step)
        begin
            for (int i = 0; i < 4; i++)
            begin
                chr_reg[i] <= chr_next[i];
            end
            cmd_reg   <= cmd_next;
            cnt_reg   <= cnt_next;
            armed_reg <= armed_next;
        end
    end

    // Result reflects the state after this request
    always_comb
    begin
        res.chr_bank_0        = chr_next[0];
        res.chr_bank_1        = chr_next[1];
        res.chr_bank_2        = chr_next[2];
        res.chr_bank_3        = chr_next[3];
        res.prg_bank          = cmd_next[2:0];
        res.mirror_horizontal = cmd_next[CMD_MIRROR_BIT];
        res.irq_pulse         = pulse;
    end

endmodule
`default_nettype wire

/* sv/cartridge_bank_mapper_with_line_irq_top.sv */
// Top level: request register, mapper state update and result register of the bank mapper.
`timescale 1ns / 1ps
`default_nettype none
// Bank mapper with a scanline interrupt counter. Each request is either a CPU
// register write (action 0) or a horizontal-blank tick (action 1), and each
// produces exactly one result showing the four 2 KB pattern banks, the 16 KB
// program bank, the mirroring and a one-result interrupt pulse. A request is
// captured in an input register, the mapper state is updated from it by one
// level of decode and a 16-bit decrement, and the result is held in an output
// register. One request is taken every cycle unless the result side stalls,
// set by the single state update stage. The input register keeps taking
// requests while a result waits, stalling only when both stages are full.
module cartridge_bank_mapper_with_line_irq_top
    import cbm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire cbm_req_t req_data,
    output logic          res_valid,
    input  wire logic     res_ready,
    output cbm_res_t      res_data
);

    logic     stage_valid_reg;
    cbm_req_t stage_reg;
    logic     res_valid_reg;
    cbm_res_t res_reg;
    cbm_res_t core_res;
    logic     exec_fire;
    logic     req_fire;

    // Advance the held request when the result register is free or draining
    assign exec_fire = stage_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !stage_valid_reg || exec_fire;
    assign req_fire  = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            stage_valid_reg <= req_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            stage_reg <= req_data;
        end
    end

    cbm_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (exec_fire),
        .req   (stage_reg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (exec_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            res_reg <= core_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

`ifndef ASSERT_OFF
    // An interrupt pulse only comes from a tick
    a_pulse_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && core_res.irq_pulse) |-> (stage_reg.action == ACT_TICK))
        else $error("irq pulse produced by a write request");

    // A held request is not dropped while the result side stalls
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !exec_fire) |=> (stage_valid_reg && $stable(stage_reg)))
        else $error("held request lost during stall");

    // An accepted request lands in the input stage
    a_req_capture: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> stage_valid_reg)
        else $error("accepted request not captured");

    // A result moving through the stage yields a valid result next cycle
    a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> res_valid_reg)
        else $error("result register not loaded");
`endif

endmodule
`default_nettype wire

/* dv/cartridge_bank_mapper_with_line_irq_top_tb.sv */
// Testbench: directed and random checks of the bank mapper with the scanline interrupt.
`timescale 1ns / 1ps
module cartridge_bank_mapper_with_line_irq_top_tb;
    import cbm_pkg::*;

    localparam int DIR_ROWS    = 25;
    localparam int RAND_ITEMS  = 925;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;

    localparam cbm_res_t MAP_CLEAR = '0;

    // One row of the directed table. Where fixed is set, the mapping in want is
    // the one to see; otherwise the predictor supplies it.
    typedef struct packed {
        cbm_req_t req;
        logic     fixed;
        cbm_res_t want;
    } dir_row_t;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     req_valid    = 1'b0;
    logic     req_ready;
    cbm_req_t req_data     = '0;
    logic     res_valid;
    logic     res_ready    = 1'b0;
    cbm_res_t res_data;

    // Shadow of the mapper state, advanced once per accepted request
    logic [7:0]  chr_bank_sh [4];
    logic [7:0]  cmd_sh;
    logic [15:0] line_cnt_sh;
    logic        armed_sh;

    // Mappings still owed by the block, oldest first
    cbm_res_t mapping_q [$];

    dir_row_t dir_tab [DIR_ROWS];

    int          fails       = 0;
    int          req_count   = 0;
    int          cycle_cnt   = 0;
    int unsigned valid_gap   = 32;
    int unsigned ready_gap   = 50;

    cartridge_bank_mapper_with_line_irq_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop: a hung handshake must not run forever.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t ns: no progress, run stopped at the cycle limit", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Advance the shadow state by one request and return the mapping it leaves.
    // A write decodes address bits 15:11; a tick counts the line counter down
    // only inside the visible window with rendering on and the interrupt armed.
    function automatic cbm_res_t map_update(input cbm_req_t r);
        cbm_res_t res;
        logic     pulse;
        pulse = 1'b0;
        if (r.action == ACT_WRITE)
        begin
            case (r.address & ADDR_MASK)
                ADDR_CHR0: chr_bank_sh[0] = r.data;
                ADDR_CHR1: chr_bank_sh[1] = r.data;
                ADDR_CHR2: chr_bank_sh[2] = r.data;
                ADDR_CHR3: chr_bank_sh[3] = r.data;
                ADDR_CNT:
                begin
                    if (cmd_sh[CMD_HIGH_BYTE_BIT])
                        line_cnt_sh[15:8] = r.data;
                    else
                        line_cnt_sh[7:0] = r.data;
                end
                ADDR_ARM:  armed_sh = r.data[ARM_DATA_BIT];
                ADDR_CMD:  cmd_sh = r.data;
                default:   ;
            endcase
        end
        else if (r.scanline <= LAST_IRQ_LINE && r.rendering_on && armed_sh
                 && line_cnt_sh != 16'd0)
        begin
            line_cnt_sh = line_cnt_sh - 16'd1;
            if (line_cnt_sh == 16'd0)
            begin
                armed_sh = 1'b0;
                pulse    = 1'b1;
            end
        end
        res.chr_bank_0        = chr_bank_sh[0];
        res.chr_bank_1        = chr_bank_sh[1];
        res.chr_bank_2        = chr_bank_sh[2];
        res.chr_bank_3        = chr_bank_sh[3];
        res.prg_bank          = cmd_sh[2:0];
        res.mirror_horizontal = cmd_sh[CMD_MIRROR_BIT];
        res.irq_pulse         = pulse;
        return res;
    endfunction

    function automatic cbm_req_t req_wr(input logic [15:0] addr, input logic [7:0] val);
        cbm_req_t r;
        r         = '0;
        r.action  = ACT_WRITE;
        r.address = addr;
        r.data    = val;
        return r;
    endfunction

    function automatic cbm_req_t req_tk(input logic [8:0] line, input logic rend);
        cbm_req_t r;
        r              = '0;
        r.action       = ACT_TICK;
        r.scanline     = line;
        r.rendering_on = rend;
        return r;
    endfunction

    // Pick a decode window: 0..3 are the pattern banks, then counter, arm,
    // command, and last any window at all (mostly unmapped).
    function automatic logic [15:0] any_window(input int unsigned last);
        case ($urandom_range(last))
            0:       return ADDR_CHR0;
            1:       return ADDR_CHR1;
            2:       return ADDR_CHR2;
            3:       return ADDR_CHR3;
            4:       return ADDR_CNT;
            5:       return ADDR_ARM;
            6:       return ADDR_CMD;
            default: return 16'($urandom) & ADDR_MASK;
        endcase
    endfunction

    // Fill the eleven bits below the decode with noise.
    function automatic logic [15:0] pick_addr(input logic [15:0] window);
        return window | (16'($urandom) & ~ADDR_MASK);
    endfunction

    task automatic report(input string field, input int want, input int got);
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        fails++;
    endtask

    task automatic check_mapping(input cbm_res_t want, input cbm_res_t got);
        if (got.chr_bank_0 !== want.chr_bank_0)
            report("chr_bank_0", want.chr_bank_0, got.chr_bank_0);
        if (got.chr_bank_1 !== want.chr_bank_1)
            report("chr_bank_1", want.chr_bank_1, got.chr_bank_1);
        if (got.chr_bank_2 !== want.chr_bank_2)
            report("chr_bank_2", want.chr_bank_2, got.chr_bank_2);
        if (got.chr_bank_3 !== want.chr_bank_3)
            report("chr_bank_3", want.chr_bank_3, got.chr_bank_3);
        if (got.prg_bank !== want.prg_bank)
            report("prg_bank", want.prg_bank, got.prg_bank);
        if (got.mirror_horizontal !== want.mirror_horizontal)
            report("mirror_horizontal", want.mirror_horizontal, got.mirror_horizontal);
        if (got.irq_pulse !== want.irq_pulse)
            report("irq_pulse", want.irq_pulse, got.irq_pulse);
    endtask

    // Result side: check what leaves the block at each edge, then redraw ready.
    // Values are read before the edge's updates land, so no race with the block.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (mapping_q.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, res_data);
                    fails++;
                end
                else
                    check_mapping(mapping_q.pop_front(), res_data);
            end
            res_ready <= ($urandom_range(99) >= ready_gap);
        end
    end

    // Offer one request: hold valid low through random gaps, then hold it high
    // with the payload steady until the block takes it. Returns at the edge of
    // acceptance, so the next call can drive without a second assignment.
    task automatic send_req(input cbm_req_t r, input logic fixed, input cbm_res_t want);
        cbm_res_t pred;
        while ($urandom_range(99) < valid_gap)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (!req_ready);
        pred = map_update(r);
        mapping_q.push_back(fixed ? want : pred);
        req_count++;
    endtask

    // One burst of random requests. Most bursts load the counter through both
    // byte lanes, arm the interrupt and tick, so that pulses come often; the
    // rest is noise across every field.
    task automatic run_burst();
        cbm_req_t    burst [$];
        cbm_req_t    r;
        logic [63:0] raw;
        int unsigned n;
        if ($urandom_range(9) < 7)
        begin
            burst.push_back(req_wr(pick_addr(ADDR_CMD), 8'($urandom) | 8'h01));
            burst.push_back(req_wr(pick_addr(ADDR_CNT),
                                   ($urandom_range(7) == 0) ? 8'($urandom) : 8'h00));
            burst.push_back(req_wr(pick_addr(ADDR_CMD), 8'($urandom) & 8'hFE));
            burst.push_back(req_wr(pick_addr(ADDR_CNT), 8'($urandom_range(10))));
            burst.push_back(req_wr(pick_addr(ADDR_ARM),
                                   ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom) | 8'h10));
            n = $urandom_range(14, 2);
            repeat (n)
            begin
                if ($urandom_range(5) == 0)
                    burst.push_back(req_wr(pick_addr(any_window(3)), 8'($urandom)));
                r = req_tk(($urandom_range(7) == 0) ? 9'($urandom_range(511, 241))
                                                    : 9'($urandom_range(240)),
                           $urandom_range(7) != 0);
                r.address = 16'($urandom);
                r.data    = 8'($urandom);
                burst.push_back(r);
            end
        end
        else
        begin
            n = $urandom_range(8, 1);
            repeat (n)
            begin
                raw = {$urandom, $urandom};
                r   = raw[$bits(cbm_req_t)-1:0];
                if ($urandom_range(1) == 0)
                begin
                    r.action  = ACT_WRITE;
                    r.address = pick_addr(any_window(7));
                end
                burst.push_back(r);
            end
        end
        foreach (burst[i])
            send_req(burst[i], 1'b0, MAP_CLEAR);
    endtask

    initial
    begin
        chr_bank_sh = '{default: 8'h00};
        cmd_sh      = 8'h00;
        line_cnt_sh = 16'h0000;
        armed_sh    = 1'b0;

        // Directed walk: decode edges, both counter byte lanes, every way a tick
        // can fall outside the window, the pulse, the armed-but-empty counter
        dir_tab = '{
            '{req_tk(9'd0, 1'b1),          1'b1, MAP_CLEAR},
            '{req_wr(16'h0000, 8'hFF),     1'b1, MAP_CLEAR},
            '{req_wr(16'hFFFF, 8'hFF),     1'b1, MAP_CLEAR},
            '{req_wr(16'h8000, 8'hFF),     1'b1, MAP_CLEAR},
            '{req_wr(ADDR_CHR0, 8'hFF),    1'b1,
              '{8'hFF, 8'h00, 8'h00, 8'h00, 3'd0, 1'b0, 1'b0}},
            '{req_wr(16'h9FFF, 8'h00),     1'b0, MAP_CLEAR},
            '{req_wr(ADDR_CHR2, 8'h5A),    1'b0, MAP_CLEAR},
            '{req_wr(16'hBFFF, 8'hA5),     1'b0, MAP_CLEAR},
            '{req_wr(16'hEFFF, 8'h27),     1'b0, MAP_CLEAR},
            '{req_wr(ADDR_CNT, 8'h00),     1'b0, MAP_CLEAR},
            '{req_wr(ADDR_CMD, 8'h00),     1'b0, MAP_CLEAR},
            '{req_wr(16'hCFFF, 8'h02),     1'b0, MAP_CLEAR},
            '{req_tk(9'd0, 1'b1),          1'b0, MAP_CLEAR},
            '{req_wr(ADDR_ARM, 8'h10),     1'b0, MAP_CLEAR},
            '{req_tk(9'd241, 1'b1),        1'b0, MAP_CLEAR},
            '{req_tk(9'd100, 1'b0),        1'b0, MAP_CLEAR},
            '{req_tk(LAST_IRQ_LINE, 1'b1), 1'b0, MAP_CLEAR},
            '{req_tk(9'd511, 1'b1),        1'b0, MAP_CLEAR},
            '{req_tk(9'd0, 1'b1),          1'b0, MAP_CLEAR},
            '{req_tk(9'd0, 1'b1),          1'b0, MAP_CLEAR},
            '{req_wr(ADDR_ARM, 8'hFF),     1'b0, MAP_CLEAR},
            '{req_tk(9'd0, 1'b1),          1'b0, MAP_CLEAR},
            '{req_wr(ADDR_CMD, 8'hDF),     1'b0, MAP_CLEAR},
            '{req_wr(ADDR_CNT, 8'hFF),     1'b0, MAP_CLEAR},
            '{req_wr(ADDR_ARM, 8'hEF),     1'b0, MAP_CLEAR}
        };

        // Hold reset at the start, release it once
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles 32 %, receiver 50 %
        foreach (dir_tab[i])
            send_req(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].want);
        while (req_count < DIR_ROWS + RAND_ITEMS / 3)
            run_burst();

        // Swap the pressure: sender idles 50 %, receiver 32 %
        valid_gap = 50;
        ready_gap = 32;
        while (req_count < DIR_ROWS + 2 * RAND_ITEMS / 3)
            run_burst();

        // Full rate on both sides
        valid_gap = 0;
        ready_gap = 0;
        while (req_count < DIR_ROWS + RAND_ITEMS)
            run_burst();
        req_valid <= 1'b0;

        // Drain, then keep watching the result side so that any stray result shows
        while (mapping_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/cbm_pkg.sv
sv/cbm_core.sv
sv/cartridge_bank_mapper_with_line_irq_top.sv
dv/cartridge_bank_mapper_with_line_irq_top_tb.sv
